FILE: rtl/core/lrupr_pkg.sv
// lrupr_pkg: sizes, search and update records, controller states and width helpers
// for the lru page replacement block; no dependencies
package lrupr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;

    // fixed port widths
    localparam int PAGE_NUMBER_W  = 16;
    localparam int FRAME_INDEX_W  = 4;
    localparam int EVICTED_PAGE_W = 16;
    localparam int FAULT_W        = 32;
    localparam int CFG_W          = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // internal widths
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W  = FRAME_W;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int PAGE_WIDE_W = (PAGE_BITS > PAGE_NUMBER_W) ? PAGE_BITS : PAGE_NUMBER_W;
    localparam int EVP_WIDE_W  = (PAGE_BITS > EVICTED_PAGE_W) ? PAGE_BITS : EVICTED_PAGE_W;
    localparam int FIDX_WIDE_W = (FRAME_W > FRAME_INDEX_W) ? FRAME_W : FRAME_INDEX_W;

    // search record walking down the cell chain
    typedef struct packed {
        logic                 live;
        logic [PAGE_BITS-1:0] page;
        logic [CNT_W-1:0]     pos;
        logic [CNT_W-1:0]     active;
        logic                 hit_found;
        logic [FRAME_W-1:0]   hit_idx;
        logic [RANK_W-1:0]    hit_rank;
        logic                 vacant_found;
        logic [FRAME_W-1:0]   empty_idx;
        logic [FRAME_W-1:0]   lru_idx;
        logic [RANK_W-1:0]    lru_rank;
        logic [PAGE_BITS-1:0] lru_page;
    } search_t;

    // broadcast to every cell once per reference
    typedef struct packed {
        logic                 en;
        logic                 clear;
        logic                 promote_all;
        logic [RANK_W-1:0]    limit;
        logic [PAGE_BITS-1:0] page;
    } update_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE
    } state_t;

    function automatic logic [PAGE_BITS-1:0] to_store_page(input logic [PAGE_NUMBER_W-1:0] p);
        logic [PAGE_WIDE_W-1:0] w;
        w = PAGE_WIDE_W'(p);
        return w[PAGE_BITS-1:0];
    endfunction

    function automatic logic [EVICTED_PAGE_W-1:0] to_evicted_page(input logic [PAGE_BITS-1:0] p);
        logic [EVP_WIDE_W-1:0] w;
        w = EVP_WIDE_W'(p);
        return w[EVICTED_PAGE_W-1:0];
    endfunction

    function automatic logic [FRAME_INDEX_W-1:0] to_frame_index(input logic [FRAME_W-1:0] f);
        logic [FIDX_WIDE_W-1:0] w;
        w = FIDX_WIDE_W'(f);
        return w[FRAME_INDEX_W-1:0];
    endfunction

endpackage

FILE: rtl/core/lrupr_cell.sv
// lrupr_cell: one page frame (page, valid, recency rank) plus one stage of the search chain
// depends on lrupr_pkg
module lrupr_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  lrupr_pkg::search_t rec_in,
    output lrupr_pkg::search_t rec_out,
    input  lrupr_pkg::update_t upd,
    input  logic              sel
);

    lrupr_pkg::search_t              rec_reg, rec_next;
    logic [lrupr_pkg::PAGE_BITS-1:0] page_reg, page_next;
    logic                            valid_reg, valid_next;
    logic [lrupr_pkg::RANK_W-1:0]    rank_reg, rank_next;
    logic                            in_use;
    logic [lrupr_pkg::FRAME_W-1:0]   my_idx;

    assign rec_out = rec_reg;

    always_comb
    begin
        in_use   = (rec_in.pos < rec_in.active);
        my_idx   = rec_in.pos[lrupr_pkg::FRAME_W-1:0];
        rec_next = rec_in;
        rec_next.pos = rec_in.pos + 1'b1;
        // lowest matching frame wins
        if (in_use && valid_reg && (page_reg == rec_in.page) && !rec_in.hit_found)
        begin
            rec_next.hit_found = 1'b1;
            rec_next.hit_idx   = my_idx;
            rec_next.hit_rank  = rank_reg;
        end
        if (in_use && !valid_reg && !rec_in.vacant_found)
        begin
            rec_next.vacant_found = 1'b1;
            rec_next.empty_idx    = my_idx;
        end
        // oldest frame, later frames win ties
        if (in_use && (rank_reg >= rec_in.lru_rank))
        begin
            rec_next.lru_idx  = my_idx;
            rec_next.lru_rank = rank_reg;
            rec_next.lru_page = page_reg;
        end
    end

    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.clear)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (upd.en)
        begin
            if (sel)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
                page_next  = upd.page;
            end
            else if (valid_reg && (upd.promote_all || (rank_reg < upd.limit)))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg   <= '0;
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            rec_reg   <= rec_next;
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

FILE: rtl/core/lru_page_replacement.sv
// lru_page_replacement: lru page replacement over a row of frame cells
// an accepted reference is registered at the head and steps through the cell chain one cell per cycle;
// the finished search is captured in the hold register, then decided and written to the output registers
// once the output is free; a new reference is accepted only in idle, after the previous result is issued
// reset: all frames empty, fault count zero, frames_in_use 16
// depends on lrupr_pkg and lrupr_cell
module lru_page_replacement (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lrupr_pkg::PAGE_NUMBER_W-1:0]   page_number,
    input  logic                                  end_of_string,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic [lrupr_pkg::FRAME_INDEX_W-1:0]   frame_index,
    output logic                                  evicted_valid,
    output logic [lrupr_pkg::EVICTED_PAGE_W-1:0]  evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]         fault_total,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]           cfg_data
);

    localparam int NF = lrupr_pkg::MAX_FRAMES;

    lrupr_pkg::state_t  state_reg, state_next;
    lrupr_pkg::search_t head_reg, head_next;
    lrupr_pkg::search_t hold_reg;
    lrupr_pkg::search_t chain [NF+1];
    lrupr_pkg::update_t upd;
    logic [NF-1:0]      sel;
    logic [NF:0]        live_vec;

    logic [lrupr_pkg::CFG_W-1:0]   frames_in_use_reg;
    logic [lrupr_pkg::CMP_W-1:0]   cfg_ext;
    logic [lrupr_pkg::CNT_W-1:0]   active;
    logic                          last_reg;
    logic [lrupr_pkg::FAULT_W-1:0] fault_count_reg, fault_count_next, fault_inc;

    logic                            capture, fire;
    logic                            dec_hit, dec_ev, dec_all;
    logic [lrupr_pkg::FRAME_W-1:0]   dec_f;
    logic [lrupr_pkg::RANK_W-1:0]    dec_limit;

    logic                                 out_valid_reg;
    logic                                 hit_reg, evicted_valid_reg;
    logic [lrupr_pkg::FRAME_INDEX_W-1:0]  frame_index_reg;
    logic [lrupr_pkg::EVICTED_PAGE_W-1:0] evicted_page_reg;
    logic [lrupr_pkg::FAULT_W-1:0]        fault_total_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frames_in_use_reg <= lrupr_pkg::CFG_RESET;
        else if (cfg_valid)
            frames_in_use_reg <= cfg_data;
    end

    // clamp to 1..MAX_FRAMES
    always_comb
    begin
        cfg_ext = lrupr_pkg::CMP_W'(frames_in_use_reg);
        if (cfg_ext == '0)
            active = lrupr_pkg::CNT_W'(1);
        else if (cfg_ext > lrupr_pkg::CMP_W'(NF))
            active = lrupr_pkg::CNT_W'(NF);
        else
            active = lrupr_pkg::CNT_W'(cfg_ext);
    end

    // controller
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        capture    = 1'b0;
        fire       = 1'b0;
        unique case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = lrupr_pkg::ST_SEARCH;
            end
            lrupr_pkg::ST_SEARCH:
            begin
                if (chain[NF].live)
                begin
                    capture    = 1'b1;
                    state_next = lrupr_pkg::ST_DECIDE;
                end
            end
            lrupr_pkg::ST_DECIDE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    fire       = 1'b1;
                    state_next = lrupr_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lrupr_pkg::ST_IDLE;
        endcase
    end

    // head of the chain: a fresh search record for one cycle after acceptance
    always_comb
    begin
        head_next      = '0;
        head_next.page = lrupr_pkg::to_store_page(page_number);
        head_next.live = in_valid && in_ready;
        head_next.active = active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrupr_pkg::ST_IDLE;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            last_reg <= end_of_string;
        if (capture)
            hold_reg <= chain[NF];
    end

    assign chain[0] = head_reg;

    for (genvar i = 0; i < NF; i++)
    begin : g_cell
        lrupr_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .rec_in  (chain[i]),
            .rec_out (chain[i+1]),
            .upd     (upd),
            .sel     (sel[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i <= NF; i++)
            live_vec[i] = chain[i].live;
    end

    // decision from the finished search
    always_comb
    begin
        dec_hit   = hold_reg.hit_found;
        dec_ev    = 1'b0;
        dec_all   = 1'b0;
        dec_f     = hold_reg.lru_idx;
        dec_limit = hold_reg.lru_rank;
        if (hold_reg.hit_found)
        begin
            dec_f     = hold_reg.hit_idx;
            dec_limit = hold_reg.hit_rank;
        end
        else if (hold_reg.vacant_found)
        begin
            dec_f   = hold_reg.empty_idx;
            dec_all = 1'b1;
        end
        else
        begin
            dec_ev = 1'b1;
        end
    end

    always_comb
    begin
        upd.en          = fire && !last_reg;
        upd.clear       = fire && last_reg;
        upd.promote_all = dec_all;
        upd.limit       = dec_limit;
        upd.page        = hold_reg.page;
        for (int i = 0; i < NF; i++)
            sel[i] = (dec_f == lrupr_pkg::FRAME_W'(i));
    end

    // saturating fault count, cleared after the last reference of a string
    always_comb
    begin
        if (dec_hit || (fault_count_reg == '1))
            fault_inc = fault_count_reg;
        else
            fault_inc = fault_count_reg + 1'b1;
        fault_count_next = fault_count_reg;
        if (fire)
            fault_count_next = last_reg ? '0 : fault_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fault_count_reg <= fault_count_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hit_reg           <= dec_hit;
            frame_index_reg   <= lrupr_pkg::to_frame_index(dec_f);
            evicted_valid_reg <= dec_ev;
            evicted_page_reg  <= dec_ev ? lrupr_pkg::to_evicted_page(hold_reg.lru_page) : '0;
            fault_total_reg   <= fault_inc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_total_reg;

    // at most one search record in the chain
    a_one_search: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live_vec))
        else $error("more than one search record in the cell chain");

    // a new reference is only taken with the chain empty
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (live_vec == '0) && !capture && !fire)
        else $error("reference accepted while a search is in flight");

    // a fault inside a string leaves a nonzero count
    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !dec_hit && !last_reg) |=> (fault_count_reg != '0))
        else $error("fault not counted");

endmodule
